### hw/rtl/gpg_pkg.sv
// shared types, constants, font rom and code mapping for the 5x8 glyph generator
// no dependencies

package gpg_pkg;

    // geometry and widths
    localparam int COORD_BITS  = 16;
    localparam int GLYPH_COUNT = 41;
    localparam int FONT_W      = 5;
    localparam int CELL_W      = 6;
    localparam int CELL_H      = 8;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(CELL_H);
    localparam int COL_W       = $clog2(CELL_W);

    // rom slots of the non-letter glyphs
    localparam int DIGIT_BASE = 26;
    localparam int IDX_DOT    = 36;
    localparam int IDX_DASH   = 37;
    localparam int IDX_COLON  = 38;
    localparam int IDX_LPAREN = 39;
    localparam int IDX_RPAREN = 40;

    // ascii codes
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // font columns, bit r of a byte is row r
    localparam logic [7:0] FONT_ROM [GLYPH_COUNT][FONT_W] = '{
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
        '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h00, 8'h60, 8'h60, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h00, 8'h00, 8'h36, 8'h36, 8'h00}, '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00},
        '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00}
    };

    // class of an incoming character code
    typedef enum logic [1:0] {
        CK_NONE,
        CK_GLYPH,
        CK_SPACE
    } t_char_kind;

    typedef struct packed {
        t_char_kind             kind;
        logic [GLYPH_IDX_W-1:0] idx;
    } t_char_map;

    // controller to datapath
    typedef struct packed {
        logic load;   // input transaction taken
        logic step;   // output transaction taken
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_char_kind kind;   // class of the code at the input
        logic       last;   // current pixel is the last of the glyph
    } t_dp_stat;

    // code to rom slot
    function automatic t_char_map map_code(logic [7:0] c);
        t_char_map m;
        m.kind = CK_NONE;
        m.idx  = '0;
        if (c >= CH_A && c <= CH_Z) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(c - CH_A);
        end else if (c >= CH_0 && c <= CH_9) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(DIGIT_BASE) + GLYPH_IDX_W'(c - CH_0);
        end else if (c == CH_DOT) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(IDX_DOT);
        end else if (c == CH_DASH) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(IDX_DASH);
        end else if (c == CH_COLON) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(IDX_COLON);
        end else if (c == CH_LPAREN) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(IDX_LPAREN);
        end else if (c == CH_RPAREN) begin
            m.kind = CK_GLYPH;
            m.idx  = GLYPH_IDX_W'(IDX_RPAREN);
        end else if (c == CH_SPACE) begin
            m.kind = CK_SPACE;
        end
        return m;
    endfunction

endpackage

### hw/rtl/gpg_ctrl.sv
// controller state machine for the glyph generator
// depends on gpg_pkg

module gpg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  gpg_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output gpg_pkg::t_dp_cmd  o_cmd
);
    import gpg_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // handshakes follow the state
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_cmd.load  = o_in_ready && i_in_valid;
    assign o_cmd.step  = o_out_valid && i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load && i_stat.kind == CK_GLYPH) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_cmd.step && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/gpg_datapath.sv
// cursor, pixel counters and font lookup for the glyph generator
// depends on gpg_pkg

module gpg_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpg_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_char_code,
    input  logic              i_first_char,
    input  logic [15:0]       i_start_x,
    input  logic [15:0]       i_start_y,
    input  logic [15:0]       i_text_color,
    output gpg_pkg::t_dp_stat o_stat,
    output logic [15:0]       o_pix_x,
    output logic [15:0]       o_pix_y,
    output logic [15:0]       o_pix_color,
    output logic              o_glyph_last
);
    import gpg_pkg::*;

    logic [COORD_BITS-1:0]  r_cursor_col;
    logic [COORD_BITS-1:0]  r_cursor_row;
    logic [COORD_BITS-1:0]  n_cursor_col;
    logic [COORD_BITS-1:0]  n_cursor_row;
    logic [ROW_W-1:0]       r_row;
    logic [COL_W-1:0]       r_col;
    logic [GLYPH_IDX_W-1:0] r_idx;
    logic [15:0]            r_color;
    t_char_map              w_map;
    logic                   w_last;
    logic [COORD_BITS-1:0]  w_x;
    logic [COORD_BITS-1:0]  w_y;
    logic [7:0]             w_font_col;
    logic                   w_lit;

    // classify the code at the input
    assign w_map       = map_code(i_char_code);
    assign w_last      = (r_row == ROW_W'(CELL_H - 1)) && (r_col == COL_W'(CELL_W - 1));
    assign o_stat.kind = w_map.kind;
    assign o_stat.last = w_last;

    // cursor update: optional load, then advance on space or finished glyph
    always_comb begin
        n_cursor_col = r_cursor_col;
        n_cursor_row = r_cursor_row;
        if (i_cmd.load) begin
            if (i_first_char) begin
                n_cursor_col = COORD_BITS'(i_start_x);
                n_cursor_row = COORD_BITS'(i_start_y);
            end
            if (w_map.kind == CK_SPACE) begin
                n_cursor_col = n_cursor_col + COORD_BITS'(CELL_W);
            end
        end
        if (i_cmd.step && w_last) begin
            n_cursor_col = r_cursor_col + COORD_BITS'(CELL_W);
        end
    end

    // cursor and pixel counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_col <= '0;
            r_cursor_row <= '0;
            r_row        <= '0;
            r_col        <= '0;
        end else begin
            r_cursor_col <= n_cursor_col;
            r_cursor_row <= n_cursor_row;
            if (i_cmd.load || (i_cmd.step && w_last)) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.step) begin
                if (r_col == COL_W'(CELL_W - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // glyph payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= w_map.idx;
            r_color <= i_text_color;
        end
    end

    // pixel fields, spacing column stays dark
    assign w_font_col   = (r_col < COL_W'(FONT_W)) ? FONT_ROM[r_idx][r_col] : 8'h00;
    assign w_lit        = w_font_col[r_row];
    assign w_x          = r_cursor_col + COORD_BITS'(r_col);
    assign w_y          = r_cursor_row + COORD_BITS'(r_row);
    assign o_pix_x      = 16'(w_x);
    assign o_pix_y      = 16'(w_y);
    assign o_pix_color  = w_lit ? r_color : 16'h0000;
    assign o_glyph_last = w_last;

endmodule

### hw/rtl/glyph_pixel_generator_5x8_unit.sv
// 5x8 glyph pixel generator: one character in, 48 pixel transactions out per glyph
// latency: first pixel is offered the cycle after the input transaction is taken
// pixel output: one pixel per cycle from the pixel counter when the output is not stalled; no new
// character is taken until the last pixel of a glyph; space and unmapped codes give no pixels
// reset: synchronous active low, cursor to (0,0), controller idle; no clearing pass
// depends on gpg_pkg, gpg_ctrl, gpg_datapath

module glyph_pixel_generator_5x8_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_first_char,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_text_color,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pix_x,
    output logic [15:0] o_pix_y,
    output logic [15:0] o_pix_color,
    output logic        o_glyph_last
);
    import gpg_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller
    gpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // datapath
    gpg_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_char_code  (i_char_code),
        .i_first_char (i_first_char),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_text_color (i_text_color),
        .o_stat       (w_stat),
        .o_pix_x      (o_pix_x),
        .o_pix_y      (o_pix_y),
        .o_pix_color  (o_pix_color),
        .o_glyph_last (o_glyph_last)
    );

`ifndef ASSERT_OFF
    // never take a character while a glyph is being emitted
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output side active together");

    // last pixel transaction returns to accepting characters
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_glyph_last) |=> o_in_ready)
        else $error("not idle after last pixel");

    // a non-last pixel transaction keeps the glyph going
    a_mid_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_glyph_last) |=> o_out_valid)
        else $error("glyph cut short");

    // a mapped glyph taken leads to pixel output
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && w_stat.kind == CK_GLYPH) |=> o_out_valid)
        else $error("glyph accepted without output");
`endif

endmodule

### dv/glyph_pixel_generator_5x8_unit_tb.sv
// self-checking testbench for glyph_pixel_generator_5x8_unit: character transactions in,
// predicted 6x8 pixel cells compared field by field with the pixel transactions out
// depends on gpg_pkg and the glyph_pixel_generator_5x8_unit rtl

module glyph_pixel_generator_5x8_unit_tb;

    import gpg_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int MAX_PRINTED    = 40;
    localparam int ITEMS_PER_PASS = 51;

    // one character transaction as offered to the block
    typedef struct packed {
        logic [7:0]  code;
        logic        first;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] color;
    } t_char_txn;

    // one pixel transaction as produced by the block
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] color;
        logic        last;
    } t_pixel;

    // font columns, column 0 in the top byte, bit r of a byte is row r
    localparam logic [39:0] GLYPH_COLS [GLYPH_COUNT] = '{
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10, 40'h2745454539,
        40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E,
        40'h0000606000, 40'h0808080808, 40'h0000363600, 40'h001C224100,
        40'h0041221C00
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_code  = '0;
    logic        i_first_char = 1'b0;
    logic [15:0] i_start_x    = '0;
    logic [15:0] i_start_y    = '0;
    logic [15:0] i_text_color = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [15:0] o_pix_x;
    logic [15:0] o_pix_y;
    logic [15:0] o_pix_color;
    logic        o_glyph_last;

    t_char_txn   pending_chars[$];
    t_pixel      pixels_due[$];
    t_char_txn   offered_char = '0;
    logic [15:0] cursor_x     = '0;
    logic [15:0] cursor_y     = '0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          chars_taken    = 0;
    int          mismatches     = 0;
    logic        hold_req       = 1'b0;
    int          hold_left      = 0;

    glyph_pixel_generator_5x8_unit DUT (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    // classify a code and give its font slot
    function automatic t_char_kind classify(input logic [7:0] c, output int slot);
        slot = 0;
        if (c >= CH_A && c <= CH_Z) begin
            slot = int'(c - CH_A);
            return CK_GLYPH;
        end
        if (c >= CH_0 && c <= CH_9) begin
            slot = DIGIT_BASE + int'(c - CH_0);
            return CK_GLYPH;
        end
        case (c)
            CH_DOT:    slot = IDX_DOT;
            CH_DASH:   slot = IDX_DASH;
            CH_COLON:  slot = IDX_COLON;
            CH_LPAREN: slot = IDX_LPAREN;
            CH_RPAREN: slot = IDX_RPAREN;
            CH_SPACE:  return CK_SPACE;
            default:   return CK_NONE;
        endcase
        return CK_GLYPH;
    endfunction

    // cursor update and pixel cell for one accepted character
    task automatic render_char(input t_char_txn t);
        int         slot;
        t_char_kind kind;
        logic [7:0] col_bits;
        t_pixel     p;
        if (t.first) begin
            cursor_x = t.sx;
            cursor_y = t.sy;
        end
        kind = classify(t.code, slot);
        if (kind == CK_SPACE) begin
            cursor_x = cursor_x + 16'(CELL_W);
        end else if (kind == CK_GLYPH) begin
            for (int r = 0; r < CELL_H; r++) begin
                for (int c = 0; c < CELL_W; c++) begin
                    col_bits = (c < FONT_W) ? GLYPH_COLS[slot][8*(FONT_W-1-c) +: 8] : 8'h00;
                    p.x      = cursor_x + 16'(c);
                    p.y      = cursor_y + 16'(r);
                    p.color  = col_bits[r] ? t.color : 16'h0000;
                    p.last   = (r == CELL_H - 1) && (c == CELL_W - 1);
                    pixels_due.push_back(p);
                end
            end
            cursor_x = cursor_x + 16'(CELL_W);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // character transactions, fed from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                render_char(offered_char);
                chars_taken <= chars_taken + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_char <= pending_chars[0];
                    i_char_code  <= pending_chars[0].code;
                    i_first_char <= pending_chars[0].first;
                    i_start_x    <= pending_chars[0].sx;
                    i_start_y    <= pending_chars[0].sy;
                    i_text_color <= pending_chars[0].color;
                    void'(pending_chars.pop_front());
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid   <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // pixel transactions, checked against the oldest predicted pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("unexpected pixel x", o_pix_x, 16'h0000);
                end else begin
                    if (o_pix_x !== pixels_due[0].x)
                        report_mismatch("pix_x", o_pix_x, pixels_due[0].x);
                    if (o_pix_y !== pixels_due[0].y)
                        report_mismatch("pix_y", o_pix_y, pixels_due[0].y);
                    if (o_pix_color !== pixels_due[0].color)
                        report_mismatch("pix_color", o_pix_color, pixels_due[0].color);
                    if (o_glyph_last !== pixels_due[0].last)
                        report_mismatch("glyph_last", 16'(o_glyph_last),
                                        16'(pixels_due[0].last));
                    void'(pixels_due.pop_front());
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_char(input logic [7:0] code, input logic first,
                            input logic [15:0] sx, input logic [15:0] sy,
                            input logic [15:0] color);
        t_char_txn t;
        t.code  = code;
        t.first = first;
        t.sx    = sx;
        t.sy    = sy;
        t.color = color;
        pending_chars.push_back(t);
    endtask

    // random code, mostly printable glyphs, some spaces and unmapped codes
    function automatic logic [7:0] pick_code();
        int r;
        int kind_roll;
        kind_roll = $urandom_range(99);
        if (kind_roll < 12)
            return CH_SPACE;
        if (kind_roll < 25)
            return 8'($urandom_range(255));
        r = $urandom_range(GLYPH_COUNT - 1);
        if (r < DIGIT_BASE)
            return CH_A + 8'(r);
        if (r < IDX_DOT)
            return CH_0 + 8'(r - DIGIT_BASE);
        case (r)
            IDX_DOT:    return CH_DOT;
            IDX_DASH:   return CH_DASH;
            IDX_COLON:  return CH_COLON;
            IDX_LPAREN: return CH_LPAREN;
            default:    return CH_RPAREN;
        endcase
    endfunction

    // text strings: a cursor load on the first character and on some later ones, random content
    task automatic add_random_text(input int n_chars);
        int          pushed;
        int          word_len;
        logic [15:0] color;
        logic [15:0] sx;
        logic [15:0] sy;
        logic        first;
        pushed = 0;
        while (pushed < n_chars) begin
            word_len = $urandom_range(1, 8);
            color    = 16'($urandom);
            for (int k = 0; k < word_len && pushed < n_chars; k++) begin
                sx    = 16'($urandom);
                sy    = 16'($urandom);
                first = (k == 0) || ($urandom_range(99) < 8);
                // keep some strings near the wrap point
                if (first && $urandom_range(7) == 0) begin
                    sx = 16'hFFFF - 16'($urandom_range(20));
                    sy = 16'hFFFF - 16'($urandom_range(10));
                end
                if ($urandom_range(9) == 0)
                    color = 16'($urandom);
                add_char(pick_code(), first, sx, sy, color);
                pushed++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || i_in_valid || pixels_due.size() != 0)
            @(posedge i_clk);
    endtask

    // directed sequence, then random phases with different idling
    initial begin
        int taken_base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every printable glyph class, extreme colors
        add_char("A", 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("Z", 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_char("0", 1'b0, 16'h0000, 16'h0000, 16'hAAAA);
        add_char("9", 1'b0, 16'h0000, 16'h0000, 16'h5555);
        add_char(CH_DOT, 1'b0, 16'h0000, 16'h0000, 16'hF800);
        add_char(CH_DASH, 1'b0, 16'h0000, 16'h0000, 16'h07E0);
        add_char(CH_COLON, 1'b0, 16'h0000, 16'h0000, 16'h001F);
        add_char(CH_LPAREN, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char(CH_RPAREN, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        // space moves the cursor with no pixels
        add_char(CH_SPACE, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("Q", 1'b0, 16'h0000, 16'h0000, 16'h1234);
        // unmapped codes: control, lower case, high codes, neighbors of mapped ranges
        add_char(8'h00, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("a", 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char(8'hFF, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char(8'h80, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("@", 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("[", 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("/", 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char(";", 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        add_char("K", 1'b0, 16'h0000, 16'h0000, 16'hC3C3);
        // coordinates wrapping within the cell
        add_char("M", 1'b1, 16'hFFFC, 16'hFFFD, 16'hFFFF);
        // cursor load on a space, then wrap past the top
        add_char(CH_SPACE, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_char("W", 1'b0, 16'h0000, 16'h0000, 16'h8001);
        // cursor load on an unmapped code still takes effect
        add_char("b", 1'b1, 16'h0123, 16'h4567, 16'hFFFF);
        add_char("B", 1'b0, 16'h0000, 16'h0000, 16'h7FFE);

        // no idling, with a long receiver hold-off early on
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        add_random_text(ITEMS_PER_PASS);
        taken_base = chars_taken;
        while (chars_taken < taken_base + 3)
            @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        wait_drained();

        // sender idle
        send_idle_pct  <= 55;
        recv_stall_pct <= 0;
        add_random_text(ITEMS_PER_PASS);
        wait_drained();

        // receiver stalling
        send_idle_pct  <= 0;
        recv_stall_pct <= 55;
        add_random_text(ITEMS_PER_PASS);
        wait_drained();

        // both
        send_idle_pct  <= 14;
        recv_stall_pct <= 14;
        add_random_text(ITEMS_PER_PASS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("TIMEOUT at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/gpg_pkg.sv
hw/rtl/gpg_ctrl.sv
hw/rtl/gpg_datapath.sv
hw/rtl/glyph_pixel_generator_5x8_unit.sv
dv/glyph_pixel_generator_5x8_unit_tb.sv
